// File: rtl/bilinear_image_rotator_assert.svh
// Assertion macros for the bilinear image rotator.
// Included by modules that assert; no other dependencies.
`ifndef BILINEAR_IMAGE_ROTATOR_ASSERT_SVH
`define BILINEAR_IMAGE_ROTATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BIR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BIR_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  `BIR_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)
`else
`define BIR_ASSERT(lbl, clk, rstn, prop, msg)
`define BIR_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/bir_pkg.sv
// Shared types and constants of the bilinear image rotator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bir_pkg;
  localparam int FRAC_BITS = 14;
  localparam int NUM_CH    = 4;
  localparam int BANK_AW   = 14;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_COS      = 3'd3,
    REG_SIN      = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_e;

  typedef struct packed {
    action_e     act;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    action_e     act;
    logic        inb;
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [13:0] fx;
    logic [13:0] fy;
    logic [31:0] data;
  } map_t;
endpackage
`default_nettype wire

// File: rtl/bir_if.sv
// Channel interfaces of the bilinear image rotator: pixel in, pixel out, config.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface bir_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [7:0] chan0_in;
  logic [7:0] chan1_in;
  logic [7:0] chan2_in;
  logic [7:0] chan3_in;
  modport source (output valid, action, x_pos, y_pos, chan0_in, chan1_in, chan2_in,
                  chan3_in, input ready);
  modport sink (input valid, action, x_pos, y_pos, chan0_in, chan1_in, chan2_in,
                chan3_in, output ready);
endinterface

interface bir_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0_out;
  logic [7:0] chan1_out;
  logic [7:0] chan2_out;
  logic [7:0] chan3_out;
  logic       in_bounds;
  modport source (output valid, chan0_out, chan1_out, chan2_out, chan3_out, in_bounds,
                  input ready);
  modport sink (input valid, chan0_out, chan1_out, chan2_out, chan3_out, in_bounds,
                output ready);
endinterface

interface bir_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/bir_mapper.sv
// Inverse coordinate mapper: three stages from pixel to source floor/fraction.
// Depends on bir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bir_mapper (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire bir_pkg::item_t      item_i,
  input  wire logic [8:0]          width_i,
  input  wire logic [8:0]          height_i,
  input  wire logic signed [15:0]  cos_i,
  input  wire logic signed [15:0]  sin_i,
  output bir_pkg::map_t            map_o
);
  import bir_pkg::*;

  item_t              item1_q, item2_q;
  logic signed [10:0] d2x_d, d2y_d, d2x_q, d2y_q;
  logic signed [26:0] pcx_q, psy_q, pcy_q, psx_q;
  logic signed [27:0] sum_x, sum_y;
  logic signed [28:0] sx, sy;
  logic signed [14:0] x0f, y0f;
  logic               inb;
  map_t               map_d, map_q;

  assign d2x_d = $signed({2'b00, item_i.x, 1'b0}) - $signed({2'b00, width_i});
  assign d2y_d = $signed({2'b00, item_i.y, 1'b0}) - $signed({2'b00, height_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item1_q <= item_i;
      d2x_q   <= d2x_d;
      d2y_q   <= d2y_d;
      item2_q <= item1_q;
      pcx_q   <= cos_i * d2x_q;
      psy_q   <= sin_i * d2y_q;
      pcy_q   <= cos_i * d2y_q;
      psx_q   <= sin_i * d2x_q;
      map_q   <= map_d;
    end
  end

  always_comb begin
    sum_x = 28'(pcx_q) + 28'(psy_q);
    sum_y = 28'(pcy_q) - 28'(psx_q);
    sx    = 29'(sum_x >>> 1) + $signed({7'b0, width_i, 13'b0});
    sy    = 29'(sum_y >>> 1) + $signed({7'b0, height_i, 13'b0});
    x0f   = sx[28:14];
    y0f   = sy[28:14];
    inb   = !x0f[14] && !y0f[14] &&
            ((x0f + 15'sd1) < $signed({6'b0, width_i})) &&
            ((y0f + 15'sd1) < $signed({6'b0, height_i}));
    map_d.act  = item2_q.act;
    map_d.inb  = inb;
    map_d.x0   = (item2_q.act == ACT_LOAD) ? item2_q.x : x0f[7:0];
    map_d.y0   = (item2_q.act == ACT_LOAD) ? item2_q.y : y0f[7:0];
    map_d.fx   = sx[13:0];
    map_d.fy   = sy[13:0];
    map_d.data = item2_q.data;
  end

  assign map_o = map_q;
endmodule
`default_nettype wire

// File: rtl/bir_store.sv
// Frame store in four banks split by row and column parity; one read per bank per word.
// Depends on bir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bir_store (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire bir_pkg::map_t     map_i,
  output bir_pkg::map_t          map_o,
  output logic [3:0][31:0]       quad_o
);
  import bir_pkg::*;

  logic [3:0][31:0] bank_rd;
  map_t             map_q;
  logic [1:0]       sel00;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int BX = b % 2;
    localparam int BY = b / 2;
    logic [31:0]        mem [2**BANK_AW];
    logic [31:0]        rd_q;
    logic [6:0]         col, row;
    logic [BANK_AW-1:0] addr;
    logic               wsel;

    assign col  = map_i.x0[7:1] + 7'((map_i.act == ACT_COMPUTE && map_i.x0[0] && BX == 0)
                                     ? 1 : 0);
    assign row  = map_i.y0[7:1] + 7'((map_i.act == ACT_COMPUTE && map_i.y0[0] && BY == 0)
                                     ? 1 : 0);
    assign addr = {row, col};
    assign wsel = (32'(map_i.x0[0]) == BX) && (32'(map_i.y0[0]) == BY);

    always_ff @(posedge clk_i) begin
      if (en_i && vld_i) begin
        if (map_i.act == ACT_LOAD) begin
          if (wsel) mem[addr] <= map_i.data;
        end else begin
          rd_q <= mem[addr];
        end
      end
    end

    assign bank_rd[b] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) map_q <= map_i;
  end

  assign sel00     = {map_q.y0[0], map_q.x0[0]};
  assign quad_o[0] = bank_rd[sel00];
  assign quad_o[1] = bank_rd[sel00 ^ 2'b01];
  assign quad_o[2] = bank_rd[sel00 ^ 2'b10];
  assign quad_o[3] = bank_rd[sel00 ^ 2'b11];
  assign map_o     = map_q;
endmodule
`default_nettype wire

// File: rtl/bir_lane.sv
// One channel lane: horizontal blend, then vertical blend, truncated to a byte.
// Depends on bir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bir_lane (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [3:0][7:0] px_i,
  input  wire logic [13:0]     fx_i,
  input  wire logic [13:0]     fy_i,
  output logic [7:0]           pix_o
);
  import bir_pkg::*;

  localparam logic [14:0] One = 15'(1 << FRAC_BITS);

  logic [14:0] wx0, wx1, wy0, wy1;
  logic [22:0] r0_d, r1_d, r0_q, r1_q;
  logic [13:0] fy_q;
  logic [37:0] acc;
  logic [7:0]  pix_q;

  assign wx1  = {1'b0, fx_i};
  assign wx0  = One - wx1;
  assign r0_d = 23'(px_i[0]) * 23'(wx0) + 23'(px_i[1]) * 23'(wx1);
  assign r1_d = 23'(px_i[2]) * 23'(wx0) + 23'(px_i[3]) * 23'(wx1);
  assign wy1  = {1'b0, fy_q};
  assign wy0  = One - wy1;
  assign acc  = 38'(r0_q) * 38'(wy0) + 38'(r1_q) * 38'(wy1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q  <= r0_d;
      r1_q  <= r1_d;
      fy_q  <= fy_i;
      pix_q <= acc[2*FRAC_BITS +: 8];
    end
  end

  assign pix_o = pix_q;
endmodule
`default_nettype wire

// File: rtl/bilinear_image_rotator.sv
// Bilinear image rotator: 7-stage pipeline with four channel lanes and a merging stage.
// Depends on bir_pkg, bir_if, bir_mapper, bir_store, bir_lane and the assert header.
//
// Usage:
//   cfg_i   writes one register (index 0 width, 1 height, 2 channels, 3 cos, 4 sin)
//           per word; always ready. Write only while the block is idle.
//   pix_i   takes one word per clock while ready is high. action 0 stores the four channel bytes at
//           (x_pos, y_pos); action 1 asks for the rotated pixel at (x_pos, y_pos).
//   pix_o   gives one word per compute word, in order; load words give none.
// Path: a compute word passes the mapper, frame store, lane and merging registers
//   before pix_o shows it. Throughput: one word per clock when the receiver does
//   not stall, set by the four-bank frame store that serves all four neighbours in one read.
// Stall: while pix_o holds a word the receiver does not take, the whole pipeline
//   holds and pix_i.ready drops; it resumes the cycle the word is taken.
// Reset: registers return to width 256, height 256, four channels, cos 1.0,
//   sin 0; the pipeline empties. The frame store is not cleared and must be
//   loaded before it is read.
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_image_rotator_assert.svh"
module bilinear_image_rotator (
  input wire logic clk_i,
  input wire logic rst_ni,
  bir_cfg_if.sink  cfg_i,
  bir_in_if.sink   pix_i,
  bir_out_if.source pix_o
);
  import bir_pkg::*;

  logic [8:0]         width_q, height_q, width_c, height_c;
  logic [2:0]         nch_q, nch_c;
  logic signed [15:0] cos_q, sin_q;
  logic               en, acc_in;
  item_t              item;
  map_t               map3, map4;
  logic [3:0][31:0]   quad;
  logic [3:0][7:0]    lane_pix;
  logic [3:1]         vld_q;
  logic [6:4]         cmp_q;
  logic [6:5]         inb_q;
  logic               out_valid_q, out_inb_q;
  logic [3:0][7:0]    out_ch_q;
  logic [3:0][7:0]    out_ch_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      nch_q    <= 3'd4;
      cos_q    <= 16'sd16384;
      sin_q    <= 16'sd0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_WIDTH:    width_q  <= cfg_i.data[8:0];
        REG_HEIGHT:   height_q <= cfg_i.data[8:0];
        REG_CHANNELS: nch_q    <= cfg_i.data[2:0];
        REG_COS:      cos_q    <= $signed(cfg_i.data);
        REG_SIN:      sin_q    <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign width_c  = (width_q == 9'd0) ? 9'd1 : (width_q > 9'd256) ? 9'd256 : width_q;
  assign height_c = (height_q == 9'd0) ? 9'd1 : (height_q > 9'd256) ? 9'd256 : height_q;
  assign nch_c    = (nch_q == 3'd0) ? 3'd1 : (nch_q > 3'd4) ? 3'd4 : nch_q;

  assign en          = !out_valid_q || pix_o.ready;
  assign pix_i.ready = en;
  assign acc_in      = pix_i.valid && en;

  assign item.act  = action_e'(pix_i.action);
  assign item.x    = pix_i.x_pos;
  assign item.y    = pix_i.y_pos;
  assign item.data = {pix_i.chan3_in, pix_i.chan2_in, pix_i.chan1_in, pix_i.chan0_in};

  bir_mapper u_mapper (
    .clk_i    (clk_i),
    .en_i     (en),
    .item_i   (item),
    .width_i  (width_c),
    .height_i (height_c),
    .cos_i    (cos_q),
    .sin_i    (sin_q),
    .map_o    (map3)
  );

  bir_store u_store (
    .clk_i  (clk_i),
    .en_i   (en),
    .vld_i  (vld_q[3]),
    .map_i  (map3),
    .map_o  (map4),
    .quad_o (quad)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    bir_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .px_i  ({quad[3][8*c +: 8], quad[2][8*c +: 8], quad[1][8*c +: 8],
               quad[0][8*c +: 8]}),
      .fx_i  (map4.fx),
      .fy_i  (map4.fy),
      .pix_o (lane_pix[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      cmp_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[2:1], acc_in};
      cmp_q       <= {cmp_q[5:4], vld_q[3] && (map3.act == ACT_COMPUTE)};
      out_valid_q <= cmp_q[6];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      out_ch_d[c] = (inb_q[6] && (3'(c) < nch_c)) ? lane_pix[c] : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inb_q[5]  <= map4.inb;
      inb_q[6]  <= inb_q[5];
      out_ch_q  <= out_ch_d;
      out_inb_q <= inb_q[6];
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.chan0_out = out_ch_q[0];
  assign pix_o.chan1_out = out_ch_q[1];
  assign pix_o.chan2_out = out_ch_q[2];
  assign pix_o.chan3_out = out_ch_q[3];
  assign pix_o.in_bounds = out_inb_q;

  `BIR_ASSERT(a_result_lands, clk_i, rst_ni, (cmp_q[6] && en) |=> out_valid_q, "word lost")
  `BIR_IMPLY(a_oob_zero, clk_i, rst_ni, out_valid_q && !out_inb_q, out_ch_q == '0, "oob nonzero")
  `BIR_IMPLY(a_one_chan, clk_i, rst_ni, out_valid_q && (nch_c == 3'd1), out_ch_q[3:1] == '0, "lanes")
  `BIR_IMPLY(a_hold_stall, clk_i, rst_ni, !en, !pix_i.ready && out_valid_q, "stall without word")
endmodule
`default_nettype wire
